// ===== rtl/pfa_pkg.sv =====
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared widths, codes and defaults of the packed field array unit.
// ----------------------------------------------------------------------------
package pfa_pkg;

  // payload widths
  localparam int KIND_W     = 2;
  localparam int INDEX_W    = 16;
  localparam int VALUE_W    = 63;
  localparam int WIDTH_W    = 6;
  localparam int COUNT_W    = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  // store geometry
  localparam int WORD_W          = 64;
  localparam int STORE_WORDS_DEF = 1024;
  // bit positions up to 65536 words * 64 bits, with room for the end position
  localparam int BIT_POS_W       = 24;

  typedef logic [KIND_W-1:0] kind_t;

  // request kinds
  localparam kind_t KIND_READ  = 2'd0;
  localparam kind_t KIND_WRITE = 2'd1;
  localparam kind_t KIND_FILL  = 2'd2;
  localparam kind_t KIND_NONE  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ELEM_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEM_COUNT = 1'd1;

endpackage

// ===== rtl/pfa_in_if.sv =====
// ----------------------------------------------------------------------------
// pfa_in_if
// Request channel: valid/ready handshake carrying kind, index and value.
// ----------------------------------------------------------------------------
interface pfa_in_if import pfa_pkg::*; ();

  logic                 valid;
  logic                 ready;
  kind_t                kind;
  logic [INDEX_W-1:0]   index;
  logic [VALUE_W-1:0]   value;

  modport source (output valid, output kind, output index, output value, input ready);
  modport sink   (input valid, input kind, input index, input value, output ready);

endinterface

// ===== rtl/pfa_out_if.sv =====
// ----------------------------------------------------------------------------
// pfa_out_if
// Response channel: valid/ready handshake carrying read value and error flag.
// ----------------------------------------------------------------------------
interface pfa_out_if import pfa_pkg::*; ();

  logic                 valid;
  logic                 ready;
  logic [VALUE_W-1:0]   read_value;
  logic                 error;

  modport source (output valid, output read_value, output error, input ready);
  modport sink   (input valid, input read_value, input error, output ready);

endinterface

// ===== rtl/packed_field_array_unit.sv =====
// ----------------------------------------------------------------------------
// packed_field_array_unit
// Store of 64-bit words holding packed elements of a configurable width.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request word (read, write or fill of elements); rsp
//   returns exactly one response word per request: the element read, or zero,
//   and an error flag for a refused request (which then has no effect).
//   cfg_we/cfg_index/cfg_data set the element width and count; write them
//   only while no request is in flight. Each write clears the store.
// Sequencing:
//   the store is one memory with a registered read port, walked by a
//   read-modify-write sequencer, one request at a time. An accepted request
//   passes MUL (bit position) and CHECK (refusal); a refused one then goes
//   to DONE. A read or write passes RD0, RD1, RD2 if the element spans two
//   words, then DONE; a fill repeats FCHK, RD0, RD1 (RD2) per element.
// Reset and clear:
//   after reset and after each configuration write the unit runs a clearing
//   pass over all STORE_WORDS words, one word a cycle, with req.ready low.
// Stalls:
//   a finished response waits in the output register; the next request is
//   accepted meanwhile and its response is held until rsp.ready.
// ----------------------------------------------------------------------------
module packed_field_array_unit import pfa_pkg::*; #(
  parameter int STORE_WORDS = STORE_WORDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pfa_in_if.sink                req,
  pfa_out_if.source             rsp
);

  localparam int ADDR_W = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam logic [BIT_POS_W-1:0] STORE_BITS = BIT_POS_W'(STORE_WORDS * WORD_W);
  localparam logic [ADDR_W-1:0]    LAST_ADDR  = ADDR_W'(STORE_WORDS - 1);

  // sequencer states
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_CHECK = 4'd3;
  localparam logic [3:0] S_FCHK  = 4'd4;
  localparam logic [3:0] S_RD0   = 4'd5;
  localparam logic [3:0] S_RD1   = 4'd6;
  localparam logic [3:0] S_RD2   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  // word store
  logic [WORD_W-1:0] mem [STORE_WORDS];
  logic [WORD_W-1:0] mem_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  // configuration
  logic [WIDTH_W-1:0] elem_width;
  logic [COUNT_W-1:0] elem_count;

  // control and payload registers
  logic [3:0]           state;
  logic [ADDR_W-1:0]    clr_addr;
  kind_t                kind_r;
  logic [INDEX_W-1:0]   idx_r;
  logic [VALUE_W-1:0]   val_r;
  logic                 fits_r;
  logic [BIT_POS_W-1:0] first_r;
  logic [COUNT_W-1:0]   fill_cnt;
  logic [6:0]           sh_r;
  logic                 strad_r;
  logic [2*WORD_W-1:0]  mask_r;
  logic [2*WORD_W-1:0]  data_r;
  logic [WORD_W-1:0]    w0_r;
  logic [VALUE_W-1:0]   res_val;
  logic                 res_err;
  logic                 rsp_valid;
  logic [VALUE_W-1:0]   rsp_val;
  logic                 rsp_err;

  // datapath terms
  logic [ADDR_W-1:0]    word_addr;
  logic [5:0]           off;
  logic [6:0]           sh_calc;
  logic                 strad_calc;
  logic [VALUE_W-1:0]   mask63;
  logic [BIT_POS_W-1:0] end_pos;
  logic                 in_store;
  logic                 req_err;
  logic [2*WORD_W-1:0]  word_pair;
  logic [VALUE_W-1:0]   extract;
  logic [WORD_W-1:0]    merged_hi;
  logic [WORD_W-1:0]    merged_lo;
  logic                 modify;
  logic                 rsp_free;

  // element geometry
  assign word_addr  = first_r[ADDR_W+5:6];
  assign off        = first_r[5:0];
  assign sh_calc    = 7'(8'd128 - {2'b00, off} - {2'b00, elem_width});
  assign strad_calc = ({1'b0, off} + {1'b0, elem_width}) > 7'd64;
  assign mask63     = (VALUE_W'(1) << elem_width) - VALUE_W'(1);
  assign end_pos    = first_r + BIT_POS_W'(elem_width);
  assign in_store   = end_pos <= STORE_BITS;

  // refusal of a request, checked once the bit position is known
  assign req_err = (elem_width == '0) || (kind_r == KIND_NONE) ||
                   ((kind_r != KIND_FILL) &&
                    ((COUNT_W'(idx_r) >= elem_count) || !in_store)) ||
                   ((kind_r != KIND_READ) && !fits_r);

  // element extraction and word merge
  assign word_pair = (state == S_RD2) ? {w0_r, mem_q} : {mem_q, WORD_W'(0)};
  assign extract   = VALUE_W'((word_pair & mask_r) >> sh_r);
  assign merged_hi = (mem_q & ~mask_r[2*WORD_W-1:WORD_W]) | data_r[2*WORD_W-1:WORD_W];
  assign merged_lo = (mem_q & ~mask_r[WORD_W-1:0]) | data_r[WORD_W-1:0];
  assign modify    = (kind_r != KIND_READ);
  assign rsp_free  = !rsp_valid || rsp.ready;

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = word_addr;
    mem_wdata = merged_hi;
    mem_raddr = word_addr;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      S_RD1: begin
        mem_we    = modify;
        mem_raddr = word_addr + ADDR_W'(1);
      end
      S_RD2: begin
        mem_we    = modify;
        mem_waddr = word_addr + ADDR_W'(1);
        mem_wdata = merged_lo;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[mem_raddr];
  end

  // sequencer and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      elem_width <= WIDTH_W'(1);
      elem_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ELEM_WIDTH: elem_width <= cfg_data[WIDTH_W-1:0];
        CFG_ELEM_COUNT: elem_count <= cfg_data[COUNT_W-1:0];
        default: elem_count <= elem_count;
      endcase
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + ADDR_W'(1);
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            kind_r <= req.kind;
            idx_r  <= req.index;
            val_r  <= req.value;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          first_r <= BIT_POS_W'(idx_r) * BIT_POS_W'(elem_width);
          fits_r  <= (val_r >> elem_width) == '0;
          state   <= S_CHECK;
        end
        S_CHECK: begin
          res_val <= '0;
          res_err <= req_err;
          if (req_err) begin
            state <= S_DONE;
          end else if (kind_r == KIND_FILL) begin
            first_r  <= '0;
            fill_cnt <= '0;
            state    <= S_FCHK;
          end else begin
            state <= S_RD0;
          end
        end
        S_FCHK: begin
          if ((fill_cnt < elem_count) && in_store) begin
            state <= S_RD0;
          end else begin
            state <= S_DONE;
          end
        end
        S_RD0: begin
          sh_r    <= sh_calc;
          strad_r <= strad_calc;
          mask_r  <= (2*WORD_W)'(mask63) << sh_calc;
          data_r  <= (2*WORD_W)'(val_r) << sh_calc;
          state   <= S_RD1;
        end
        S_RD1: begin
          w0_r <= mem_q;
          if (strad_r) begin
            state <= S_RD2;
          end else if (kind_r == KIND_FILL) begin
            first_r  <= end_pos;
            fill_cnt <= fill_cnt + COUNT_W'(1);
            state    <= S_FCHK;
          end else begin
            if (kind_r == KIND_READ) begin
              res_val <= extract;
            end
            state <= S_DONE;
          end
        end
        S_RD2: begin
          if (kind_r == KIND_FILL) begin
            first_r  <= end_pos;
            fill_cnt <= fill_cnt + COUNT_W'(1);
            state    <= S_FCHK;
          end else begin
            if (kind_r == KIND_READ) begin
              res_val <= extract;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_DONE) && rsp_free) begin
      rsp_valid <= 1'b1;
      rsp_val   <= res_val;
      rsp_err   <= res_err;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // channel outputs
  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = rsp_valid;
  assign rsp.read_value = rsp_val;
  assign rsp.error      = rsp_err;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the packed field array unit. A driver feeds read,
// write and fill words from a queue, a monitor checks each response word
// against a bit-level model of the packed store, and the configuration is
// swept over several element widths and counts, extremes included.
// ----------------------------------------------------------------------------
module tb_top;
  import pfa_pkg::*;

  localparam int          STORE_WORDS  = STORE_WORDS_DEF;
  localparam int          SETTLE       = 16;
  localparam int unsigned LIMIT_CYCLES = 2_000_000;

  typedef struct packed {
    kind_t              kind;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
  } access_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic               error;
  } reply_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pfa_in_if  req_bus ();
  pfa_out_if rsp_bus ();

  packed_field_array_unit #(
    .STORE_WORDS(STORE_WORDS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req      (req_bus),
    .rsp      (rsp_bus)
  );

  // model state: packed store and current configuration
  logic [WORD_W-1:0] store_words [STORE_WORDS];
  logic [WIDTH_W-1:0] cur_width = 6'd1;
  logic [COUNT_W-1:0] cur_count = '0;

  access_t     access_q[$];
  reply_t      due_replies[$];
  int unsigned recent_slots[$];
  int unsigned mismatches = 0;
  int unsigned send_gap   = 0;
  int unsigned hold_left  = 0;
  bit          send_burst = 1'b0;
  bit          recv_burst = 1'b0;

  // clock, reset and known input levels
  initial begin
    clk             = 1'b0;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = CFG_ELEM_WIDTH;
    cfg_data        = '0;
    req_bus.valid   = 1'b0;
    req_bus.kind    = KIND_READ;
    req_bus.index   = '0;
    req_bus.value   = '0;
    rsp_bus.ready   = 1'b0;
    fork
      forever #5 clk = ~clk;
      begin
        repeat (12) @(posedge clk);
        rst <= 1'b0;
      end
    join_none
  end

  // run limit
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  function automatic void clear_store();
    foreach (store_words[i]) store_words[i] = '0;
  endfunction

  function automatic int unsigned effective_count();
    int unsigned cap;
    if (cur_width == 0) return 0;
    cap = (STORE_WORDS * WORD_W) / cur_width;
    return (cur_count < cap) ? cur_count : cap;
  endfunction

  // element sits in a 128-bit window of its first word and the next one
  function automatic logic [VALUE_W-1:0] elem_get(int unsigned idx);
    int unsigned first_bit, wi, sh;
    logic [127:0] pair, mask;
    first_bit = idx * cur_width;
    wi        = first_bit / WORD_W;
    sh        = 128 - (first_bit % WORD_W) - cur_width;
    pair      = {store_words[wi], (wi + 1 < STORE_WORDS) ? store_words[wi + 1] : 64'd0};
    mask      = (128'd1 << cur_width) - 128'd1;
    return VALUE_W'((pair >> sh) & mask);
  endfunction

  function automatic void elem_put(int unsigned idx, logic [VALUE_W-1:0] val);
    int unsigned first_bit, wi, sh;
    logic [127:0] pair, mask;
    first_bit = idx * cur_width;
    wi        = first_bit / WORD_W;
    sh        = 128 - (first_bit % WORD_W) - cur_width;
    pair      = {store_words[wi], (wi + 1 < STORE_WORDS) ? store_words[wi + 1] : 64'd0};
    mask      = ((128'd1 << cur_width) - 128'd1) << sh;
    pair      = (pair & ~mask) | ((128'(val) << sh) & mask);
    store_words[wi] = pair[127:64];
    if (wi + 1 < STORE_WORDS) store_words[wi + 1] = pair[63:0];
  endfunction

  // expected response of one accepted word, updating the model store
  function automatic reply_t apply_access(access_t a);
    reply_t      rep;
    int unsigned lim;
    bit          fits;
    rep  = '0;
    lim  = effective_count();
    fits = (cur_width != 0) && ((a.value >> cur_width) == '0);
    if (cur_width == 0 || a.kind == KIND_NONE) begin
      rep.error = 1'b1;
    end else if (a.kind == KIND_READ) begin
      if (a.index < lim) rep.read_value = elem_get(a.index);
      else rep.error = 1'b1;
    end else if (a.kind == KIND_WRITE) begin
      if (a.index < lim && fits) elem_put(a.index, a.value);
      else rep.error = 1'b1;
    end else if (fits) begin
      for (int unsigned i = 0; i < lim; i++) elem_put(i, a.value);
    end else begin
      rep.error = 1'b1;
    end
    return rep;
  endfunction

  function automatic int unsigned pick_idle(inout bit burst);
    if ($urandom_range(0, 31) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 3);
  endfunction

  // request driver
  always @(posedge clk) begin : req_driver
    bit go;
    go = 1'b0;
    if (rst) begin
      req_bus.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        due_replies.push_back(apply_access(access_q.pop_front()));
        send_gap = pick_idle(send_burst);
        go = (send_gap == 0);
      end else if (!req_bus.valid) begin
        if (send_gap != 0) send_gap--;
        go = (send_gap == 0);
      end
      // a stalled word holds its payload
      if (!(req_bus.valid && !req_bus.ready)) begin
        if (go && access_q.size() != 0) begin
          req_bus.valid <= 1'b1;
          req_bus.kind  <= access_q[0].kind;
          req_bus.index <= access_q[0].index;
          req_bus.value <= access_q[0].value;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor and ready stalls
  always @(posedge clk) begin : rsp_monitor
    reply_t want;
    if (rst) begin
      rsp_bus.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (due_replies.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected word: value %h error %0b", rsp_bus.read_value,
                     rsp_bus.error);
          mismatches++;
        end else begin
          want = due_replies.pop_front();
          if (rsp_bus.read_value !== want.read_value || rsp_bus.error !== want.error) begin
            if (mismatches < 10)
              $display("mismatch: expected value %h error %0b, got value %h error %0b",
                       want.read_value, want.error, rsp_bus.read_value, rsp_bus.error);
            mismatches++;
          end
        end
        hold_left = pick_idle(recv_burst);
        if (hold_left != 0) rsp_bus.ready <= 1'b0;
      end else if (!rsp_bus.ready) begin
        if (hold_left != 0) hold_left--;
        if (hold_left == 0) rsp_bus.ready <= 1'b1;
      end
    end
  end

  task automatic wait_idle();
    while (access_q.size() != 0 || due_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] ri, logic [CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= ri;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (ri == CFG_ELEM_WIDTH) cur_width = d[WIDTH_W-1:0];
    else cur_count = d[COUNT_W-1:0];
    clear_store();
  endtask

  // reconfigure once all outstanding words are back
  task automatic set_config(logic [WIDTH_W-1:0] w, logic [COUNT_W-1:0] c, bit count_first);
    wait_idle();
    repeat (SETTLE) @(posedge clk);
    if (count_first) write_reg(CFG_ELEM_COUNT, CFG_DATA_W'(c));
    write_reg(CFG_ELEM_WIDTH, CFG_DATA_W'(w));
    if (!count_first) write_reg(CFG_ELEM_COUNT, CFG_DATA_W'(c));
    recent_slots.delete();
    @(negedge clk);
  endtask

  function automatic void add_access(kind_t k, int unsigned ix, logic [VALUE_W-1:0] v);
    access_t a;
    a.kind  = k;
    a.index = INDEX_W'(ix);
    a.value = v;
    access_q.push_back(a);
  endfunction

  // random words; fitting fills over the whole store are capped by fills
  task automatic add_random(int n, int fills);
    int unsigned        lim, r, ix;
    kind_t              k;
    logic [63:0]        raw;
    logic [VALUE_W-1:0] v, fit_mask;
    bit                 fits;
    lim      = effective_count();
    fit_mask = (cur_width == 0) ? '0 : (VALUE_W'(1) << cur_width) - VALUE_W'(1);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 38) k = KIND_READ;
      else if (r < 80) k = KIND_WRITE;
      else if (r < 95) k = KIND_FILL;
      else k = KIND_NONE;

      // index: mostly in range, revisiting recent writes
      r = $urandom_range(0, 99);
      if (r < 8) ix = $urandom_range(0, 65535);
      else if (r < 14 && lim <= 65535) ix = $urandom_range(lim, 65535);
      else if (r < 18 && lim != 0) ix = lim - 1;
      else if (r < 50 && recent_slots.size() != 0)
        ix = recent_slots[$urandom_range(0, recent_slots.size() - 1)];
      else if (lim != 0) ix = $urandom_range(0, lim - 1);
      else ix = $urandom_range(0, 65535);

      // value: mostly fitting, some too wide
      raw = {$urandom, $urandom};
      r   = $urandom_range(0, 99);
      if (r < 8 && cur_width < VALUE_W)
        v = (raw[VALUE_W-1:0] & fit_mask) |
            (VALUE_W'(1) << $urandom_range(cur_width, VALUE_W - 1));
      else if (r < 14) v = fit_mask;
      else if (r < 18) v = '0;
      else if (r < 22) v = raw[VALUE_W-1:0];
      else v = raw[VALUE_W-1:0] & fit_mask;

      fits = (cur_width != 0) && ((v & ~fit_mask) == '0);
      if (k == KIND_FILL && fits && lim != 0) begin
        if (fills == 0) k = KIND_READ;
        else fills--;
      end
      if (k == KIND_WRITE && fits && ix < lim) begin
        recent_slots.push_back(ix);
        if (recent_slots.size() > 8) void'(recent_slots.pop_front());
      end
      add_access(k, ix, v);
    end
  endtask

  // stimulus
  initial begin
    logic [WIDTH_W-1:0] rw;
    logic [COUNT_W-1:0] rc;
    clear_store();
    @(negedge clk);

    // reset settings: one-bit elements, none in use
    add_access(KIND_FILL, 0, 63'd1);
    add_access(KIND_FILL, 0, 63'd2);
    add_access(KIND_READ, 0, '0);
    add_random(20, 4);

    // widest elements, count past capacity: most elements span words
    set_config(6'd63, 17'h10000, 1'b0);
    add_access(KIND_WRITE, 0, 63'h7FFF_FFFF_FFFF_FFFF);
    add_access(KIND_READ, 0, '0);
    add_access(KIND_WRITE, 1039, 63'd1);
    add_access(KIND_READ, 1039, '0);
    add_access(KIND_READ, 1040, '0);
    add_access(KIND_WRITE, 1040, 63'd5);
    add_access(KIND_READ, 65535, '0);
    add_access(KIND_NONE, 7, 63'h7FFF_FFFF_FFFF_FFFF);
    add_access(KIND_FILL, 0, 63'h2AAA_AAAA_AAAA_AAAA);
    add_access(KIND_READ, 517, '0);
    add_random(150, 5);

    // one-bit elements filling the whole store, full index range
    set_config(6'd1, 17'h10000, 1'b1);
    add_access(KIND_WRITE, 65535, 63'd1);
    add_access(KIND_READ, 65535, '0);
    add_access(KIND_WRITE, 0, 63'd2);
    add_access(KIND_FILL, 0, 63'd3);
    add_access(KIND_FILL, 0, 63'd1);
    add_access(KIND_WRITE, 40000, 63'd0);
    add_access(KIND_READ, 40000, '0);
    add_random(120, 0);

    set_config(6'd7, 17'd100, 1'b0);
    add_random(150, 10);

    set_config(6'd32, 17'd2048, 1'b1);
    add_random(100, 3);

    // zero width refuses everything
    set_config(6'd0, 17'd50, 1'b0);
    add_access(KIND_WRITE, 3, 63'd0);
    add_access(KIND_FILL, 0, 63'd0);
    add_access(KIND_NONE, 0, 63'd0);
    add_random(20, 4);

    set_config(6'd13, 17'h10000, 1'b0);
    add_random(80, 1);

    set_config(6'd63, 17'd1, 1'b1);
    add_random(30, 5);

    set_config(6'd17, 17'd0, 1'b0);
    add_random(20, 4);

    // assorted small settings
    repeat (4) begin
      rw = $urandom_range(1, 63);
      rc = $urandom_range(0, 300);
      set_config(rw, rc, $urandom_range(0, 1));
      add_random(40, 4);
    end

    wait_idle();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== packed_field_array_unit.f =====
rtl/pfa_pkg.sv
rtl/pfa_in_if.sv
rtl/pfa_out_if.sv
rtl/packed_field_array_unit.sv
dv/tb_top.sv
